### hdl/focipcp_pkg.sv
// Shared constants, types and the sine table for the inverse Park/Clarke PWM stage.
// No dependencies; every module of the block imports this package.
package focipcp_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int SINE_DEPTH = 1024;
  localparam int IDX_BITS   = $clog2(SINE_DEPTH);
  localparam int SQRT3_Q14  = 28378;
  localparam int DIV_STAGES = 16;
  localparam int XW         = 44;   // clamped phase voltage, twice its value in Q28

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] trig_t;
  typedef trig_t sine_rom_t [SINE_DEPTH];

  // sine of a Q32 turn fraction, Q1.14, integer Taylor series in Q30
  function automatic trig_t sine_q14(logic [31:0] t);
    logic [1:0]  quad;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    quad = t[31:30];
    f    = {34'd0, t[29:0]};
    if (quad[0]) begin
      f = ONE_Q30 - f;
    end
    x  = (f * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd110;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd72;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd42;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd20;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd6;
    s  = (x * r) >> 30;
    s  = (s + (64'd1 << 15)) >> 16;
    if (quad[1]) begin
      s = -s;
    end
    return trig_t'(s[15:0]);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      rom[i] = sine_q14(32'(i) << (32 - IDX_BITS));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### hdl/focipcp_angle.sv
// Front stages: Uq clamp, electrical angle, sine/cosine ROM lookup.
// Depends on focipcp_pkg.
module focipcp_angle
  import focipcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] uq_i,
  input  logic signed [15:0] ud_i,
  input  logic [15:0]        shaft_angle_i,
  input  logic [6:0]         pole_pairs_i,
  input  logic [15:0]        zero_offset_i,
  input  logic [14:0]        bus_voltage_i,
  output logic               valid_o,
  output logic signed [15:0] uq_o,
  output logic signed [15:0] ud_o,
  output trig_t              sin_o,
  output trig_t              cos_o
);

  logic signed [15:0]  half;
  logic signed [15:0]  uq_clamp;
  logic [22:0]         mech_prod;
  logic [15:0]         elec;
  logic [IDX_BITS-1:0] cos_idx;

  logic                vld_a_q, vld_b_q;
  logic signed [15:0]  uq_a_q, ud_a_q, uq_b_q, ud_b_q;
  logic [IDX_BITS-1:0] idx_a_q;
  trig_t               sin_q, cos_q;

  always_comb begin
    half = $signed({2'b00, bus_voltage_i[14:1]});
    if (uq_i > half) begin
      uq_clamp = half;
    end else if (uq_i < -half) begin
      uq_clamp = -half;
    end else begin
      uq_clamp = uq_i;
    end
    mech_prod = shaft_angle_i * pole_pairs_i;
    elec      = mech_prod[15:0] - zero_offset_i;
    cos_idx   = idx_a_q + IDX_BITS'(SINE_DEPTH / 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uq_a_q  <= uq_clamp;
      ud_a_q  <= ud_i;
      idx_a_q <= elec[ANGLE_BITS-1 -: IDX_BITS];
      uq_b_q  <= uq_a_q;
      ud_b_q  <= ud_a_q;
      sin_q   <= SINE_ROM[idx_a_q];
      cos_q   <= SINE_ROM[cos_idx];
    end
  end

  assign valid_o = vld_b_q;
  assign uq_o    = uq_b_q;
  assign ud_o    = ud_b_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

### hdl/focipcp_transform.sv
// Inverse Park and inverse Clarke stages, phase voltage clamp to [0, bus].
// Depends on focipcp_pkg.
module focipcp_transform
  import focipcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] uq_i,
  input  logic signed [15:0] ud_i,
  input  trig_t              sin_i,
  input  trig_t              cos_i,
  input  logic [14:0]        bus_voltage_i,
  output logic               valid_o,
  output logic [XW-1:0]      xa_o,
  output logic [XW-1:0]      xb_o,
  output logic [XW-1:0]      xc_o
);

  logic               vld_p_q, vld_s_q, vld_t_q, vld_x_q;
  logic signed [31:0] p_us_q, p_dc_q, p_uc_q, p_ds_q;
  logic signed [32:0] alpha_q, beta_q;
  logic signed [48:0] term_q;
  logic signed [46:0] alpha38_q;
  logic [XW-1:0]      xa_q, xb_q, xc_q;

  logic signed [50:0] bus38, bus2, va, vb, vc;
  logic signed [15:0] sqrt3;

  function automatic logic [XW-1:0] clamp_v(logic signed [50:0] v, logic signed [50:0] lim);
    logic [XW-1:0] res;
    if (v <= 51'sd0) begin
      res = '0;
    end else if (v > lim) begin
      res = lim[XW-1:0];
    end else begin
      res = v[XW-1:0];
    end
    return res;
  endfunction

  always_comb begin
    sqrt3 = 16'(SQRT3_Q14);
    bus38 = $signed({8'd0, bus_voltage_i, 28'd0});
    bus2  = bus38 <<< 1;
    va    = (51'(alpha38_q) <<< 1) + bus38;
    vb    = 51'(term_q) - 51'(alpha38_q) + bus38;
    vc    = -51'(term_q) - 51'(alpha38_q) + bus38;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
      vld_s_q <= 1'b0;
      vld_t_q <= 1'b0;
      vld_x_q <= 1'b0;
    end else if (en_i) begin
      vld_p_q <= valid_i;
      vld_s_q <= vld_p_q;
      vld_t_q <= vld_s_q;
      vld_x_q <= vld_t_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_us_q    <= uq_i * sin_i;
      p_dc_q    <= ud_i * cos_i;
      p_uc_q    <= uq_i * cos_i;
      p_ds_q    <= ud_i * sin_i;
      alpha_q   <= 33'(p_dc_q) - 33'(p_us_q);
      beta_q    <= 33'(p_uc_q) + 33'(p_ds_q);
      term_q    <= 49'(beta_q) * 49'(sqrt3);
      alpha38_q <= 47'(alpha_q) <<< 14;
      xa_q      <= clamp_v(va, bus2);
      xb_q      <= clamp_v(vb, bus2);
      xc_q      <= clamp_v(vc, bus2);
    end
  end

  assign valid_o = vld_x_q;
  assign xa_o    = xa_q;
  assign xb_o    = xb_q;
  assign xc_o    = xc_q;

endmodule

### hdl/focipcp_scale.sv
// One phase: voltage times PWM period, then pipelined restoring division by bus.
// Depends on focipcp_pkg.
module focipcp_scale
  import focipcp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [15:0]   pwm_period_i,
  input  logic [14:0]   bus_voltage_i,
  output logic          valid_o,
  output logic [15:0]   compare_o
);

  localparam int HALF = XW / 2;

  logic                     vld_m_q, vld_n_q;
  logic [HALF+15:0]         lo_m_q;
  logic [XW-HALF+15:0]      hi_m_q;
  logic [XW+15:0]           prod;
  logic [30:0]              num_q;

  logic        vld_q [DIV_STAGES];
  logic [14:0] rem_q [DIV_STAGES];
  logic [15:0] low_q [DIV_STAGES];
  logic [15:0] quo_q [DIV_STAGES];

  logic [14:0] rem_in [DIV_STAGES];
  logic [15:0] low_in [DIV_STAGES];
  logic [15:0] quo_in [DIV_STAGES];
  logic        vld_in [DIV_STAGES];
  logic [14:0] rem_d  [DIV_STAGES];
  logic [15:0] quo_d  [DIV_STAGES];
  logic [15:0] trial  [DIV_STAGES];

  always_comb begin
    prod = {hi_m_q, {HALF{1'b0}}} + (XW+16)'(lo_m_q);
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem_in[k] = num_q[30:16];
        low_in[k] = num_q[15:0];
        quo_in[k] = '0;
        vld_in[k] = vld_n_q;
      end else begin
        rem_in[k] = rem_q[k-1];
        low_in[k] = low_q[k-1];
        quo_in[k] = quo_q[k-1];
        vld_in[k] = vld_q[k-1];
      end
      trial[k] = {rem_in[k], low_in[k][15]};
      if (trial[k] >= {1'b0, bus_voltage_i}) begin
        rem_d[k] = 15'(trial[k] - {1'b0, bus_voltage_i});
        quo_d[k] = {quo_in[k][14:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][14:0];
        quo_d[k] = {quo_in[k][14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
      vld_n_q <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_m_q <= valid_i;
      vld_n_q <= vld_m_q;
      for (int k = 0; k < DIV_STAGES; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_m_q <= x_i[HALF-1:0] * pwm_period_i;
      hi_m_q <= x_i[XW-1:HALF] * pwm_period_i;
      num_q  <= prod[59:29];
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= {low_in[k][14:0], 1'b0};
        quo_q[k] <= quo_d[k];
      end
    end
  end

  // zero bus: force zero compare instead of the all-ones quotient
  assign valid_o   = vld_q[DIV_STAGES-1];
  assign compare_o = (bus_voltage_i == '0) ? '0 : quo_q[DIV_STAGES-1];

endmodule

### hdl/foc_inverse_park_clarke_pwm_top.sv
// Top level of the inverse Park/Clarke sinusoidal PWM stage: APB registers,
// pipeline control and output register. Depends on focipcp_pkg and its submodules.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------------
//   input    | in        | in_valid_i / in_stall_o | uq_i, ud_i, shaft_angle_i
//   output   | out       | out_valid_o / out_stall_i | compare_a_o, compare_b_o, compare_c_o
//   config   | in/out    | APB psel/penable/pready | paddr, pwdata, prdata
//
// One word can enter every cycle while the pipeline is not stalled; from acceptance a word
// passes the angle and table lookup registers, the transform registers, the period
// product registers, the division stages by the bus voltage and the output register.
// The whole pipeline advances together and holds only while the output word is
// stalled; then in_stall_o is high and no new word enters, bubbles included.
// Reset clears all valid bits and loads register defaults.
module foc_inverse_park_clarke_pwm_top
  import focipcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] uq_i,
  input  logic signed [15:0] ud_i,
  input  logic [15:0]        shaft_angle_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        compare_a_o,
  output logic [15:0]        compare_b_o,
  output logic [15:0]        compare_c_o,
  // APB register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    REG_POLE_PAIRS  = 2'd0,
    REG_ZERO_OFFSET = 2'd1,
    REG_BUS_VOLTAGE = 2'd2,
    REG_PWM_PERIOD  = 2'd3
  } reg_idx_e;

  logic [6:0]  pole_pairs_q;
  logic [15:0] zero_offset_q;
  logic [14:0] bus_voltage_q;
  logic [15:0] pwm_period_q;

  logic        cfg_wr;
  reg_idx_e    reg_idx;
  logic        en;

  logic               ang_vld;
  logic signed [15:0] ang_uq, ang_ud;
  trig_t              ang_sin, ang_cos;
  logic               xf_vld;
  logic [XW-1:0]      xa, xb, xc;
  logic               sa_vld, sb_vld, sc_vld;
  logic [15:0]        cmp_a, cmp_b, cmp_c;

  logic               out_valid_q, out_valid_d;
  logic [15:0]        cmp_a_q, cmp_b_q, cmp_c_q;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pairs_q  <= 7'd11;
      zero_offset_q <= 16'd0;
      bus_voltage_q <= 15'd12288;
      pwm_period_q  <= 16'd6000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_POLE_PAIRS:  pole_pairs_q  <= pwdata[6:0];
        REG_ZERO_OFFSET: zero_offset_q <= pwdata[15:0];
        REG_BUS_VOLTAGE: bus_voltage_q <= pwdata[14:0];
        REG_PWM_PERIOD:  pwm_period_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLE_PAIRS:  prdata = {25'd0, pole_pairs_q};
      REG_ZERO_OFFSET: prdata = {16'd0, zero_offset_q};
      REG_BUS_VOLTAGE: prdata = {17'd0, bus_voltage_q};
      REG_PWM_PERIOD:  prdata = {16'd0, pwm_period_q};
      default:         prdata = '0;
    endcase
  end

  // advance the pipe unless the output word is held
  assign en         = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~en;

  focipcp_angle u_angle (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .uq_i          (uq_i),
    .ud_i          (ud_i),
    .shaft_angle_i (shaft_angle_i),
    .pole_pairs_i  (pole_pairs_q),
    .zero_offset_i (zero_offset_q),
    .bus_voltage_i (bus_voltage_q),
    .valid_o       (ang_vld),
    .uq_o          (ang_uq),
    .ud_o          (ang_ud),
    .sin_o         (ang_sin),
    .cos_o         (ang_cos)
  );

  focipcp_transform u_transform (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (ang_vld),
    .uq_i          (ang_uq),
    .ud_i          (ang_ud),
    .sin_i         (ang_sin),
    .cos_i         (ang_cos),
    .bus_voltage_i (bus_voltage_q),
    .valid_o       (xf_vld),
    .xa_o          (xa),
    .xb_o          (xb),
    .xc_o          (xc)
  );

  focipcp_scale u_scale_a (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (xf_vld),
    .x_i           (xa),
    .pwm_period_i  (pwm_period_q),
    .bus_voltage_i (bus_voltage_q),
    .valid_o       (sa_vld),
    .compare_o     (cmp_a)
  );

  focipcp_scale u_scale_b (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (xf_vld),
    .x_i           (xb),
    .pwm_period_i  (pwm_period_q),
    .bus_voltage_i (bus_voltage_q),
    .valid_o       (sb_vld),
    .compare_o     (cmp_b)
  );

  focipcp_scale u_scale_c (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (xf_vld),
    .x_i           (xc),
    .pwm_period_i  (pwm_period_q),
    .bus_voltage_i (bus_voltage_q),
    .valid_o       (sc_vld),
    .compare_o     (cmp_c)
  );

  // all three phase lanes run in lock step
  assign out_valid_d = sa_vld & sb_vld & sc_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmp_a_q <= cmp_a;
      cmp_b_q <= cmp_b;
      cmp_c_q <= cmp_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign compare_a_o = cmp_a_q;
  assign compare_b_o = cmp_b_q;
  assign compare_c_o = cmp_c_q;

endmodule
